// ===== rtl/hcs_pkg.sv =====
`timescale 1ns / 1ps
// hcs_pkg: shared types, widths and codes of the hop capture sequencer
// no dependencies; imported by every module of the block

package hcs_pkg;

  localparam int unsigned HopsDefault = 4;

  localparam int unsigned KindW    = 2;
  localparam int unsigned CountW   = 16;
  localparam int unsigned GatherW  = 24;
  localparam int unsigned PauseW   = 28;
  localparam int unsigned RateW    = 30;
  localparam int unsigned CntW     = 29;
  localparam int unsigned BufW     = 4;
  localparam int unsigned StepW    = 4;
  localparam int unsigned FreqW    = 34;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 96;

  typedef enum logic [KindW-1:0] {
    KIND_BLOCK  = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GATHER = 2'd0,
    REG_PAUSE  = 2'd1,
    REG_RATE   = 2'd2
  } cfg_reg_e;

  typedef enum logic [5:0] {
    MODE_STOPPED   = 6'b000001,
    MODE_STARTING  = 6'b000010,
    MODE_GATHERING = 6'b000100,
    MODE_PAUSING   = 6'b001000,
    MODE_AWAIT     = 6'b010000,
    MODE_RESULT    = 6'b100000
  } mode_e;

  localparam logic [PhaseW-1:0] PHASE_STOPPED   = 3'd0;
  localparam logic [PhaseW-1:0] PHASE_STARTING  = 3'd1;
  localparam logic [PhaseW-1:0] PHASE_GATHERING = 3'd2;
  localparam logic [PhaseW-1:0] PHASE_PAUSING   = 3'd3;
  localparam logic [PhaseW-1:0] PHASE_AWAIT     = 3'd4;
  localparam logic [PhaseW-1:0] PHASE_RESULT    = 3'd5;

  typedef struct packed {
    logic              dropped;
    logic [CountW-1:0] sample_count;
    logic [KindW-1:0]  kind;
  } item_t;

  typedef struct packed {
    logic [RateW-1:0]   sample_rate;
    logic [PauseW-1:0]  pause_samples;
    logic [GatherW-1:0] gather_samples;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic               deliver;
    logic               data_ready;
    logic [FreqW-1:0]   freq_offset;
    logic [StepW-1:0]   hop_step;
    logic               hop_valid;
    logic [CountW-1:0]  copy_count;
    logic [GatherW-1:0] copy_offset;
    logic [BufW-1:0]    copy_buffer;
    logic               copy_valid;
  } result_t;

  function automatic logic [PhaseW-1:0] phase_of(mode_e m);
    logic [PhaseW-1:0] p;
    unique case (m)
      MODE_STOPPED:   p = PHASE_STOPPED;
      MODE_STARTING:  p = PHASE_STARTING;
      MODE_GATHERING: p = PHASE_GATHERING;
      MODE_PAUSING:   p = PHASE_PAUSING;
      MODE_AWAIT:     p = PHASE_AWAIT;
      MODE_RESULT:    p = PHASE_RESULT;
      default:        p = PHASE_STOPPED;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/hcs_cfg_regs.sv =====
`timescale 1ns / 1ps
// hcs_cfg_regs: configuration register file of the hop capture sequencer
// depends on hcs_pkg

module hcs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hcs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hcs_pkg::CfgDataW-1:0]    cfg_data_i,
  output hcs_pkg::cfg_t                   cfg_o
);
  import hcs_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_index_i)
        REG_GATHER: cfg_d.gather_samples = cfg_data_i[GatherW-1:0];
        REG_PAUSE:  cfg_d.pause_samples  = cfg_data_i[PauseW-1:0];
        REG_RATE:   cfg_d.sample_rate    = cfg_data_i[RateW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gather_samples <= GatherW'(1);
      cfg_q.pause_samples  <= '0;
      cfg_q.sample_rate    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hcs_in_stage.sv =====
`timescale 1ns / 1ps
// hcs_in_stage: input register of the sequencer, one item deep
// depends on hcs_pkg

module hcs_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hcs_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hcs_pkg::item_t item_o
);
  import hcs_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/hcs_seq_core.sv =====
`timescale 1ns / 1ps
// hcs_seq_core: capture mode, buffer index and sample counter, plus the
// per-item result logic; depends on hcs_pkg

module hcs_seq_core #(
  parameter int unsigned HOPS = hcs_pkg::HopsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  hcs_pkg::item_t   item_i,
  input  hcs_pkg::cfg_t    cfg_i,
  output hcs_pkg::result_t result_o
);
  import hcs_pkg::*;

  localparam int unsigned IdxW     = $clog2(HOPS + 1);
  localparam int unsigned HalfHops = HOPS / 2;
  localparam int unsigned WideStep = 6;

  mode_e             mode_q, mode_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic [IdxW-1:0]     idx_g;
  logic [IdxW-1:0]     idx_inc;
  logic [GatherW-1:0]  cnt_g;
  logic                start_blk;
  logic                pause_end;
  logic                go_gather;
  logic [CntW-1:0]     pause_sum;
  logic [GatherW:0]    gather_sum;
  logic [GatherW-1:0]  remain;
  logic [WideStep-1:0] step_raw;
  logic [StepW-1:0]    step;
  logic signed [FreqW:0] hop_prod;
  result_t             res;

  assign start_blk = (mode_q == MODE_STOPPED) || (mode_q == MODE_STARTING);
  assign pause_sum = cnt_q + CntW'(item_i.sample_count);
  assign pause_end = (mode_q == MODE_PAUSING) && (pause_sum > CntW'(cfg_i.pause_samples));
  // the block that ends the pause is gathered from offset zero
  assign idx_g     = start_blk ? '0 : idx_q;
  assign cnt_g     = (start_blk || pause_end) ? '0 : cnt_q[GatherW-1:0];

  assign idx_inc   = idx_g + IdxW'(1);
  assign step_raw  = WideStep'(idx_inc) - WideStep'(HalfHops);
  assign step      = step_raw[StepW-1:0];
  assign hop_prod  = $signed(step) * $signed({1'b0, cfg_i.sample_rate});
  assign gather_sum = {1'b0, cnt_g} + (GatherW + 1)'(item_i.sample_count);
  assign remain    = (cnt_g < cfg_i.gather_samples) ? cfg_i.gather_samples - cnt_g : '0;

  always_comb begin
    mode_d    = mode_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    go_gather = 1'b0;
    res       = '0;

    unique case (item_i.kind)
      KIND_BLOCK: begin
        unique case (mode_q)
          MODE_STOPPED, MODE_STARTING: go_gather = 1'b1;
          MODE_PAUSING: begin
            if (pause_end) begin
              go_gather = 1'b1;
            end else begin
              cnt_d = pause_sum;
            end
          end
          MODE_GATHERING: go_gather = 1'b1;
          MODE_RESULT: begin
            mode_d      = MODE_STARTING;
            res.deliver = 1'b1;
          end
          MODE_AWAIT: ;
          default: ;
        endcase

        if (go_gather) begin
          mode_d = MODE_GATHERING;
          idx_d  = idx_g;
          if (item_i.dropped) begin
            cnt_d = '0;
          end else begin
            res.copy_valid  = 1'b1;
            res.copy_buffer = BufW'(idx_g);
            res.copy_offset = cnt_g;
            if (gather_sum < {1'b0, cfg_i.gather_samples}) begin
              res.copy_count = item_i.sample_count;
              cnt_d          = CntW'(gather_sum);
            end else begin
              // last block of this buffer, trimmed to the space left
              res.copy_count = remain[CountW-1:0];
              idx_d          = idx_inc;
              cnt_d          = '0;
              if (idx_inc >= IdxW'(HOPS)) begin
                mode_d         = MODE_AWAIT;
                res.data_ready = 1'b1;
              end else begin
                mode_d          = MODE_PAUSING;
                res.hop_valid   = 1'b1;
                res.hop_step    = step;
                res.freq_offset = hop_prod[FreqW-1:0];
              end
            end
          end
        end
      end
      KIND_FINISH: begin
        if (mode_q == MODE_AWAIT) begin
          mode_d = MODE_RESULT;
        end
      end
      KIND_STOP: begin
        // hop back to the center frequency
        if (mode_q != MODE_STOPPED) begin
          mode_d        = MODE_STOPPED;
          res.hop_valid = 1'b1;
        end
      end
      default: ;
    endcase

    res.phase = phase_of(mode_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_STOPPED;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
    end
  end

  assign result_o = res;

endmodule

// ===== rtl/hcs_out_stage.sv =====
`timescale 1ns / 1ps
// hcs_out_stage: result register toward the output channel
// depends on hcs_pkg

module hcs_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  hcs_pkg::result_t result_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output hcs_pkg::result_t result_o
);
  import hcs_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== rtl/hop_capture_sequencer_unit.sv =====
`timescale 1ns / 1ps
// hop_capture_sequencer_unit: top level of the hop capture sequencer
// depends on hcs_pkg, hcs_cfg_regs, hcs_in_stage, hcs_seq_core, hcs_out_stage
//
// channel   direction  handshake               payload
// s_axis    in         s_axis_tvalid/tready    tdata sample_count, tuser kind, dropped
// m_axis    out        m_axis_tvalid/tready    tdata all result fields
// cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one item per cycle sustained while the output is not stalled; a result passes
// the input register, then the result register, before it can leave
// mode, buffer index and counter update in the cycle the item leaves the input
// register, so items follow each other without gaps
// a stalled output holds its result; the input register still takes one item
// reset at once clears mode, counters and both valid flags, sets config defaults

module hop_capture_sequencer_unit #(
  parameter int unsigned HOPS = hcs_pkg::HopsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hcs_pkg::InDataW-1:0]   s_axis_tdata,  // [15:0] sample_count
  input  logic [hcs_pkg::InUserW-1:0]   s_axis_tuser,  // [1:0] kind, [2] dropped
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] copy_valid, [4:1] copy_buffer, [28:5] copy_offset, [44:29] copy_count,
  // [45] hop_valid, [49:46] hop_step, [83:50] freq_offset, [84] data_ready,
  // [85] deliver, [88:86] phase, [95:89] zero
  output logic [hcs_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hcs_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hcs_pkg::*;

  localparam int unsigned ResW = $bits(result_t);

  cfg_t    cfg;
  item_t   in_item, core_item;
  logic    core_valid, out_ready, advance;
  result_t core_res, out_res;

  assign in_item.kind         = s_axis_tuser[KindW-1:0];
  assign in_item.dropped      = s_axis_tuser[KindW];
  assign in_item.sample_count = s_axis_tdata[CountW-1:0];

  hcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcs_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (core_valid),
    .ready_i (out_ready),
    .item_o  (core_item)
  );

  // item moves from input register into the result register
  assign advance = core_valid && out_ready;

  hcs_seq_core #(
    .HOPS (HOPS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (core_item),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  hcs_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (core_res),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {(OutDataW - ResW)'(0), out_res};

endmodule

// ===== tb/sv/tb_hop_capture_sequencer_unit.sv =====
`timescale 1ns / 1ps
// tb_hop_capture_sequencer_unit: self-checking bench for the hop capture sequencer
// depends on hcs_pkg and hop_capture_sequencer_unit; a local predictor checks every result

module tb_hop_capture_sequencer_unit;
  import hcs_pkg::*;

  localparam int unsigned Hops        = hcs_pkg::HopsDefault;
  localparam int unsigned ResW        = $bits(result_t);
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  hop_capture_sequencer_unit #(
    .HOPS(Hops)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] sample_count
    .s_axis_tuser  (s_axis_tuser),   // [1:0] kind, [2] dropped
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // copy, hop, data_ready, deliver, phase fields
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state and register copies
  logic [GatherW-1:0] gather_len = 24'd1;
  logic [PauseW-1:0]  pause_len  = '0;
  logic [RateW-1:0]   rate_hz    = '0;
  logic [PhaseW-1:0]  cap_mode   = PHASE_STOPPED;
  logic [4:0]         cap_buf    = '0;
  logic [CntW-1:0]    cap_count  = '0;

  item_t   block_q[$];
  result_t seq_result_q[$];
  item_t   on_bus;
  result_t got_res;
  result_t want_res;
  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_gap_pct   = 28;
  int unsigned rx_stall_pct = 55;

  function automatic void order_hop(ref result_t r, input int step);
    longint shift;
    shift = longint'(step) * longint'(rate_hz);
    r.hop_valid   = 1'b1;
    r.hop_step    = StepW'(step);
    r.freq_offset = FreqW'(shift);
  endfunction

  function automatic result_t advance_capture(item_t it);
    result_t r;
    logic [GatherW-1:0] space;
    r = '0;
    case (it.kind)
      KIND_BLOCK: begin
        if (cap_mode == PHASE_STOPPED) cap_mode = PHASE_STARTING;
        if (cap_mode == PHASE_STARTING) begin
          cap_buf   = '0;
          cap_count = '0;
          cap_mode  = PHASE_GATHERING;
        end
        if (cap_mode == PHASE_PAUSING) begin
          cap_count = cap_count + it.sample_count;
          // pause ends only once the count is strictly past the limit
          if (cap_count > pause_len) begin
            cap_count = '0;
            cap_mode  = PHASE_GATHERING;
          end
        end
        if (cap_mode == PHASE_GATHERING) begin
          if (it.dropped) begin
            cap_count = '0;
          end else begin
            r.copy_valid  = 1'b1;
            r.copy_buffer = cap_buf[BufW-1:0];
            r.copy_offset = cap_count[GatherW-1:0];
            if (cap_count + it.sample_count < gather_len) begin
              r.copy_count = it.sample_count;
              cap_count    = cap_count + it.sample_count;
            end else begin
              // space left is zero when the register dropped below the counter
              space = (cap_count < gather_len) ? gather_len - cap_count[GatherW-1:0] : '0;
              r.copy_count = space[CountW-1:0];
              cap_buf   = cap_buf + 5'd1;
              cap_count = '0;
              if (cap_buf >= Hops) begin
                cap_mode     = PHASE_AWAIT;
                r.data_ready = 1'b1;
              end else begin
                order_hop(r, int'(cap_buf) - int'(Hops / 2));
                cap_mode = PHASE_PAUSING;
              end
            end
          end
        end else if (cap_mode == PHASE_RESULT) begin
          cap_mode  = PHASE_STARTING;
          r.deliver = 1'b1;
        end
      end
      KIND_FINISH: begin
        if (cap_mode == PHASE_AWAIT) cap_mode = PHASE_RESULT;
      end
      KIND_STOP: begin
        if (cap_mode != PHASE_STOPPED) begin
          cap_mode = PHASE_STOPPED;
          order_hop(r, 0);
        end
      end
      default: ;
    endcase
    r.phase = cap_mode;
    return r;
  endfunction

  // input side: holds the current item until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seq_result_q.push_back(advance_capture(on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (block_q.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
          on_bus = block_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.sample_count;
          s_axis_tuser  <= {on_bus.dropped, on_bus.kind};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // output side: random back-pressure, checks every result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = result_t'(m_axis_tdata[ResW-1:0]);
        if (seq_result_q.size() == 0) begin
          fault_count++;
          $display("%t: result expected none, got %0h", $time, m_axis_tdata);
        end else begin
          want_res = seq_result_q.pop_front();
          check_field("copy_valid", want_res.copy_valid, got_res.copy_valid);
          check_field("copy_buffer", want_res.copy_buffer, got_res.copy_buffer);
          check_field("copy_offset", want_res.copy_offset, got_res.copy_offset);
          check_field("copy_count", want_res.copy_count, got_res.copy_count);
          check_field("hop_valid", want_res.hop_valid, got_res.hop_valid);
          check_field("hop_step", want_res.hop_step, got_res.hop_step);
          check_field("freq_offset", want_res.freq_offset, got_res.freq_offset);
          check_field("data_ready", want_res.data_ready, got_res.data_ready);
          check_field("deliver", want_res.deliver, got_res.deliver);
          check_field("phase", want_res.phase, got_res.phase);
          check_field("pad", 0, m_axis_tdata[OutDataW-1:ResW]);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(logic [KindW-1:0] k, int unsigned n, logic d);
    item_t it;
    it.kind         = k;
    it.sample_count = n[CountW-1:0];
    it.dropped      = d;
    block_q.push_back(it);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_GATHER: gather_len = val[GatherW-1:0];
      REG_PAUSE:  pause_len  = val[PauseW-1:0];
      REG_RATE:   rate_hz    = val[RateW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_capture_regs(int unsigned g, int unsigned p, int unsigned r);
    write_reg(REG_GATHER, g);
    write_reg(REG_PAUSE, p);
    write_reg(REG_RATE, r);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (block_q.size() != 0 || s_axis_tvalid || seq_result_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic start_phase(int unsigned tx_pct, int unsigned rx_pct);
    @(negedge clk_i);
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // captures with random block sizes, a little noise, each closed by finish and delivery
  task automatic queue_captures(int unsigned count, int unsigned blk_max, int unsigned per_buf);
    int unsigned queued;
    int unsigned fed;
    int unsigned n;
    int unsigned pick;
    logic        drop;
    queued = 0;
    while (queued < count) begin
      fed = 0;
      while (fed < Hops * per_buf && queued < count) begin
        pick = $urandom_range(99);
        n    = $urandom_range(blk_max);
        drop = ($urandom_range(19) == 0);
        if (pick < 3) begin
          queue_item(KIND_STOP, $urandom_range(16'hFFFF), drop);
        end else if (pick < 6) begin
          queue_item(KIND_FINISH, $urandom_range(16'hFFFF), drop);
        end else if (pick < 8) begin
          queue_item(KIND_SPARE, $urandom_range(16'hFFFF), drop);
        end else begin
          queue_item(KIND_BLOCK, n, drop);
          if (!drop) fed += n;
        end
        queued++;
      end
      queue_item(KIND_BLOCK, $urandom_range(blk_max), 1'b0);
      queue_item(KIND_FINISH, 0, 1'b0);
      queue_item(KIND_BLOCK, $urandom_range(blk_max), 1'($urandom_range(1)));
      queued += 3;
    end
  endtask

  initial begin
    int unsigned g;
    int unsigned p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: one-sample buffers, no pause, zero rate
    start_phase(28, 55);
    queue_item(KIND_FINISH, 0, 1'b0);
    queue_item(KIND_STOP, 0, 1'b0);
    queue_item(KIND_SPARE, 16'hFFFF, 1'b1);
    queue_item(KIND_BLOCK, 0, 1'b0);
    queue_item(KIND_BLOCK, 16'hFFFF, 1'b0);
    queue_item(KIND_BLOCK, 0, 1'b0);
    queue_item(KIND_BLOCK, 1, 1'b1);
    queue_item(KIND_BLOCK, 16'hFFFF, 1'b0);
    queue_item(KIND_BLOCK, 2, 1'b0);
    queue_item(KIND_BLOCK, 1, 1'b0);
    queue_item(KIND_BLOCK, 9, 1'b0);
    queue_item(KIND_FINISH, 0, 1'b0);
    queue_item(KIND_FINISH, 0, 1'b0);
    queue_item(KIND_BLOCK, 4, 1'b0);
    queue_item(KIND_SPARE, 0, 1'b0);
    queue_item(KIND_STOP, 0, 1'b0);
    queue_item(KIND_BLOCK, 5, 1'b1);
    queue_item(KIND_STOP, 16'hFFFF, 1'b1);
    wait_idle();

    set_capture_regs(100, 50, 30'h3FFF_FFFF);
    start_phase(28, 55);
    queue_item(KIND_BLOCK, 30, 1'b0);
    queue_item(KIND_BLOCK, 30, 1'b1);
    queue_item(KIND_BLOCK, 80, 1'b0);
    queue_item(KIND_BLOCK, 30, 1'b0);
    queue_item(KIND_BLOCK, 50, 1'b0);
    queue_item(KIND_BLOCK, 1, 1'b0);
    queue_item(KIND_BLOCK, 60, 1'b0);
    wait_idle();
    // gather register lowered under the running counter
    write_reg(REG_GATHER, 10);
    start_phase(28, 55);
    queue_item(KIND_BLOCK, 7, 1'b0);
    wait_idle();
    write_reg(REG_GATHER, 0);
    start_phase(28, 55);
    queue_item(KIND_BLOCK, 60, 1'b0);
    queue_item(KIND_STOP, 0, 1'b0);
    wait_idle();

    set_capture_regs(200, 100, $urandom_range(30'h3FFF_FFFF));
    start_phase(28, 55);
    queue_captures(200, 120, 200 + 100 + 1 + 120);
    wait_idle();

    g = $urandom_range(1, 64);
    p = $urandom_range(0, 40);
    set_capture_regs(g, p, $urandom_range(30'h3FFF_FFFF));
    start_phase(55, 28);
    queue_captures(150, 48, g + p + 1 + 48);
    wait_idle();

    set_capture_regs(5000, 3000, 30'h3FFF_FFFF);
    start_phase(0, 0);
    queue_captures(150, 4000, 5000 + 3000 + 1 + 4000);
    wait_idle();

    // largest buffers and pause: offsets climb high within one buffer
    set_capture_regs(24'hFF_FFFF, 28'hFFF_FFFF, 0);
    start_phase(0, 0);
    for (int i = 0; i < 24; i++) begin
      queue_item(KIND_BLOCK, $urandom_range(60000, 16'hFFFF), (i == 11));
    end
    queue_item(KIND_STOP, 0, 1'b0);
    wait_idle();

    // one-sample buffers with the longest pause: the counter runs far in pausing
    set_capture_regs(1, 28'hFFF_FFFF, 30'h3FFF_FFFF);
    start_phase(0, 0);
    queue_item(KIND_BLOCK, 1, 1'b0);
    queue_item(KIND_BLOCK, 3, 1'b0);
    for (int i = 0; i < 15; i++) begin
      queue_item(KIND_BLOCK, 16'hFFFF, i[0]);
    end
    queue_item(KIND_FINISH, 0, 1'b0);
    queue_item(KIND_STOP, 0, 1'b0);
    wait_idle();

    if (fault_count == 0 && seq_result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== hop_capture_sequencer_unit.f =====
rtl/hcs_pkg.sv
rtl/hcs_cfg_regs.sv
rtl/hcs_in_stage.sv
rtl/hcs_seq_core.sv
rtl/hcs_out_stage.sv
rtl/hop_capture_sequencer_unit.sv
tb/sv/tb_hop_capture_sequencer_unit.sv
